// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is held
`define DDA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion, also checked across reset
`define DDA_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/dda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int POS_W      = COORD_BITS + FRAC_BITS;
    localparam int ABS_W      = COORD_BITS;
    localparam int SPAN_W     = COORD_BITS + 1;
    localparam int INC_W      = FRAC_BITS + 2;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int RND_W      = COORD_BITS + 2;
    localparam int COLOR_W    = 24;
    localparam int CANVAS_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_CYC    = POS_W;
    localparam int DIV_CNT_W  = $clog2(DIV_CYC);

    localparam int IN_DATA_W   = ((4 * COORD_BITS + COLOR_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((2 * COORD_BITS + COLOR_W + 7) / 8) * 8;
    localparam int OUT_USER_W  = 2;

    localparam logic [CANVAS_W-1:0] CANVAS_W_RESET = CANVAS_W'(1280);
    localparam logic [CANVAS_W-1:0] CANVAS_H_RESET = CANVAS_W'(720);

    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = CFG_IDX_W'(1);

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    localparam logic [POS_W:0] ROUND_HALF = (POS_W + 1)'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic start;
        logic step;
        logic idle_step;
        logic div_start;
    } dda_cmd_t;

    typedef struct packed {
        logic zero_len;
        logic last_step;
        logic out_free;
        logic div_done;
    } dda_status_t;

    // Q-format position to integer pixel, half away from zero
    function automatic logic [RND_W-1:0] round_fixed(input logic [POS_W-1:0] p);
        logic           neg;
        logic [POS_W:0] ext;
        logic [POS_W:0] mag;
        logic [POS_W:0] sum;
        logic [RND_W-1:0] r;
        neg = p[POS_W-1];
        ext = {p[POS_W-1], p};
        mag = neg ? (~ext + 1'b1) : ext;
        sum = mag + ROUND_HALF;
        r   = RND_W'(sum >> FRAC_BITS);
        return neg ? (~r + 1'b1) : r;
    endfunction

endpackage

`default_nettype wire

// File: sv/dda_line_rasterizer.sv
// channel   dir  handshake                 payload
// s_        in   s_tvalid / s_tready       s_tdata, s_tuser (func)
// m_        out  m_tvalid / m_tready       m_tdata, m_tuser, m_tlast (line_done)
// cfg_      in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Step items: one per cycle while s_tready stays high; each result is presented in the cycle after accept.
// Start items: first pixel registered next cycle; unless the line has zero length,
//   s_tready then stays low while the shift-subtract divider forms both increments.
// Reset: synchronous on aresetn low; canvas returns to 1280 x 720, no line active.
// Stalls: a held result blocks s_tready only while m_tready is low.
`timescale 1ns / 1ps
`default_nettype none

module dda_line_rasterizer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // start_x, start_y, end_x, end_y, line_color
    input  wire logic [dda_pkg::IN_DATA_W-1:0]      s_tdata,
    // func
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [dda_pkg::OUT_DATA_W-1:0]          m_tdata,
    // write_enable, pixel_valid
    output logic [dda_pkg::OUT_USER_W-1:0]          m_tuser,
    output logic                                    m_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dda_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dda_pkg::CANVAS_W-1:0]       cfg_data
);

    dda_pkg::dda_cmd_t    cmd;
    dda_pkg::dda_status_t status;

    assign cfg_ready = 1'b1;

    dda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dda_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// File: sv/dda_div.sv
`timescale 1ns / 1ps
`default_nettype none

// two-lane restoring divider, one quotient bit per cycle
module dda_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [dda_pkg::ABS_W-1:0]     mag_x,
    input  wire logic [dda_pkg::ABS_W-1:0]     mag_y,
    input  wire logic [dda_pkg::ABS_W-1:0]     divisor,
    output logic                               done,
    output logic [dda_pkg::QUO_W-1:0]          quo_x,
    output logic [dda_pkg::QUO_W-1:0]          quo_y
);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [dda_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [dda_pkg::ABS_W-1:0]     dsr_reg, dsr_next;
    logic [dda_pkg::POS_W-1:0]     dvd_reg  [2];
    logic [dda_pkg::POS_W-1:0]     dvd_next [2];
    logic [dda_pkg::ABS_W-1:0]     rem_reg  [2];
    logic [dda_pkg::ABS_W-1:0]     rem_next [2];
    logic [dda_pkg::ABS_W-1:0]     mag_in   [2];

    assign mag_in[0] = mag_x;
    assign mag_in[1] = mag_y;

    always_comb begin
        logic [dda_pkg::ABS_W:0] shifted;
        logic                    ge;
        shifted   = '0;
        ge        = 1'b0;
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dsr_next  = dsr_reg;
        for (int l = 0; l < 2; l++) begin
            dvd_next[l] = dvd_reg[l];
            rem_next[l] = rem_reg[l];
        end
        if (start) begin
            run_next = 1'b1;
            cnt_next = '0;
            dsr_next = divisor;
            for (int l = 0; l < 2; l++) begin
                dvd_next[l] = {mag_in[l], {dda_pkg::FRAC_BITS{1'b0}}};
                rem_next[l] = '0;
            end
        end else if (run_reg) begin
            for (int l = 0; l < 2; l++) begin
                shifted     = {rem_reg[l], dvd_reg[l][dda_pkg::POS_W-1]};
                ge          = shifted >= {1'b0, dsr_reg};
                rem_next[l] = ge ? dda_pkg::ABS_W'(shifted - {1'b0, dsr_reg})
                                 : shifted[dda_pkg::ABS_W-1:0];
                dvd_next[l] = {dvd_reg[l][dda_pkg::POS_W-2:0], ge};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == dda_pkg::DIV_CNT_W'(dda_pkg::DIV_CYC - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dsr_reg <= dsr_next;
        for (int l = 0; l < 2; l++) begin
            dvd_reg[l] <= dvd_next[l];
            rem_reg[l] <= rem_next[l];
        end
    end

    assign done  = done_reg;
    assign quo_x = dvd_reg[0][dda_pkg::QUO_W-1:0];
    assign quo_y = dvd_reg[1][dda_pkg::QUO_W-1:0];

endmodule

`default_nettype wire

// File: sv/dda_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module dda_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire dda_pkg::dda_cmd_t                 cmd,
    output dda_pkg::dda_status_t                   status,
    input  wire logic [dda_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic                              cfg_valid,
    input  wire logic [dda_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dda_pkg::CANVAS_W-1:0]      cfg_data,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic [dda_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic [dda_pkg::OUT_USER_W-1:0]         m_tuser,
    output logic                                   m_tlast
);

    localparam int CB = dda_pkg::COORD_BITS;

    logic [CB-1:0]                  start_x, start_y, end_x, end_y;
    logic [dda_pkg::COLOR_W-1:0]    line_color;
    logic [dda_pkg::SPAN_W-1:0]     dx, dy, ndx, ndy;
    logic [dda_pkg::ABS_W-1:0]      ax, ay, steps;

    logic [dda_pkg::POS_W-1:0]      pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [dda_pkg::INC_W-1:0]      inc_x_reg, inc_x_next, inc_y_reg, inc_y_next;
    logic [dda_pkg::ABS_W-1:0]      steps_left_reg, steps_left_next;
    logic [dda_pkg::COLOR_W-1:0]    color_reg, color_next;
    logic                           sign_x_reg, sign_x_next, sign_y_reg, sign_y_next;
    logic [dda_pkg::CANVAS_W-1:0]   canvas_w_reg, canvas_w_next;
    logic [dda_pkg::CANVAS_W-1:0]   canvas_h_reg, canvas_h_next;

    logic                           m_valid_reg, m_valid_next;
    logic [CB-1:0]                  out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [dda_pkg::COLOR_W-1:0]    out_color_reg, out_color_next;
    logic                           out_we_reg, out_we_next;
    logic                           out_pv_reg, out_pv_next;
    logic                           out_done_reg, out_done_next;

    logic                           div_done;
    logic [dda_pkg::QUO_W-1:0]      quo_x, quo_y;
    logic [dda_pkg::RND_W-1:0]      px, py;
    logic                           on_canvas;

    assign start_x    = s_tdata[CB-1:0];
    assign start_y    = s_tdata[2*CB-1:CB];
    assign end_x      = s_tdata[3*CB-1:2*CB];
    assign end_y      = s_tdata[4*CB-1:3*CB];
    assign line_color = s_tdata[4*CB+dda_pkg::COLOR_W-1:4*CB];

    assign dx    = {end_x[CB-1], end_x} - {start_x[CB-1], start_x};
    assign dy    = {end_y[CB-1], end_y} - {start_y[CB-1], start_y};
    assign ndx   = ~dx + 1'b1;
    assign ndy   = ~dy + 1'b1;
    assign ax    = dx[dda_pkg::SPAN_W-1] ? ndx[dda_pkg::ABS_W-1:0] : dx[dda_pkg::ABS_W-1:0];
    assign ay    = dy[dda_pkg::SPAN_W-1] ? ndy[dda_pkg::ABS_W-1:0] : dy[dda_pkg::ABS_W-1:0];
    assign steps = (ax > ay) ? ax : ay;

    dda_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .mag_x   (ax),
        .mag_y   (ay),
        .divisor (steps),
        .done    (div_done),
        .quo_x   (quo_x),
        .quo_y   (quo_y)
    );

    always_comb begin
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        inc_x_next      = inc_x_reg;
        inc_y_next      = inc_y_reg;
        steps_left_next = steps_left_reg;
        color_next      = color_reg;
        sign_x_next     = sign_x_reg;
        sign_y_next     = sign_y_reg;
        if (cmd.start) begin
            pos_x_next      = {start_x, {dda_pkg::FRAC_BITS{1'b0}}};
            pos_y_next      = {start_y, {dda_pkg::FRAC_BITS{1'b0}}};
            steps_left_next = steps;
            color_next      = line_color;
            sign_x_next     = dx[dda_pkg::SPAN_W-1];
            sign_y_next     = dy[dda_pkg::SPAN_W-1];
        end else if (cmd.step) begin
            pos_x_next = pos_x_reg + {{(dda_pkg::POS_W - dda_pkg::INC_W){inc_x_reg[dda_pkg::INC_W-1]}},
                                      inc_x_reg};
            pos_y_next = pos_y_reg + {{(dda_pkg::POS_W - dda_pkg::INC_W){inc_y_reg[dda_pkg::INC_W-1]}},
                                      inc_y_reg};
            steps_left_next = steps_left_reg - 1'b1;
        end
        if (div_done) begin
            inc_x_next = sign_x_reg ? (~{1'b0, quo_x} + 1'b1) : {1'b0, quo_x};
            inc_y_next = sign_y_reg ? (~{1'b0, quo_y} + 1'b1) : {1'b0, quo_y};
        end
    end

    always_comb begin
        canvas_w_next = canvas_w_reg;
        canvas_h_next = canvas_h_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                dda_pkg::CFG_CANVAS_WIDTH:  canvas_w_next = cfg_data;
                dda_pkg::CFG_CANVAS_HEIGHT: canvas_h_next = cfg_data;
                default: ;
            endcase
        end
    end

    assign px        = dda_pkg::round_fixed(pos_x_next);
    assign py        = dda_pkg::round_fixed(pos_y_next);
    assign on_canvas = !px[dda_pkg::RND_W-1] && (px < dda_pkg::RND_W'(canvas_w_reg))
                    && !py[dda_pkg::RND_W-1] && (py < dda_pkg::RND_W'(canvas_h_reg));

    always_comb begin
        m_valid_next   = m_valid_reg && !m_tready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_we_next    = out_we_reg;
        out_pv_next    = out_pv_reg;
        out_done_next  = out_done_reg;
        if (cmd.start || cmd.step) begin
            m_valid_next   = 1'b1;
            out_x_next     = px[CB-1:0];
            out_y_next     = py[CB-1:0];
            out_color_next = color_next;
            out_we_next    = on_canvas;
            out_pv_next    = 1'b1;
            out_done_next  = cmd.start ? status.zero_len : status.last_step;
        end else if (cmd.idle_step) begin
            m_valid_next   = 1'b1;
            out_x_next     = '0;
            out_y_next     = '0;
            out_color_next = '0;
            out_we_next    = 1'b0;
            out_pv_next    = 1'b0;
            out_done_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            inc_x_reg      <= '0;
            inc_y_reg      <= '0;
            steps_left_reg <= '0;
            color_reg      <= '0;
            sign_x_reg     <= 1'b0;
            sign_y_reg     <= 1'b0;
            canvas_w_reg   <= dda_pkg::CANVAS_W_RESET;
            canvas_h_reg   <= dda_pkg::CANVAS_H_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            inc_x_reg      <= inc_x_next;
            inc_y_reg      <= inc_y_next;
            steps_left_reg <= steps_left_next;
            color_reg      <= color_next;
            sign_x_reg     <= sign_x_next;
            sign_y_reg     <= sign_y_next;
            canvas_w_reg   <= canvas_w_next;
            canvas_h_reg   <= canvas_h_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_we_reg    <= out_we_next;
        out_pv_reg    <= out_pv_next;
        out_done_reg  <= out_done_next;
    end

    assign status.zero_len  = (steps == '0);
    assign status.last_step = (steps_left_reg == dda_pkg::ABS_W'(1));
    assign status.out_free  = !m_valid_reg || m_tready;
    assign status.div_done  = div_done;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = dda_pkg::OUT_DATA_W'({out_color_reg, out_y_reg, out_x_reg});
    assign m_tuser  = {out_pv_reg, out_we_reg};
    assign m_tlast  = out_done_reg;

endmodule

`default_nettype wire

// File: sv/dda_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dda_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tuser,
    output logic                       s_tready,
    input  wire dda_pkg::dda_status_t  status,
    output dda_pkg::dda_cmd_t          cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    assign cmd.start     = accept && (s_tuser == dda_pkg::FUNC_START);
    assign cmd.step      = accept && (s_tuser == dda_pkg::FUNC_STEP) && busy_reg;
    assign cmd.idle_step = accept && (s_tuser == dda_pkg::FUNC_STEP) && !busy_reg;
    assign cmd.div_start = cmd.start && !status.zero_len;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (cmd.div_start) state_next = ST_DIV;
            ST_DIV:  if (status.div_done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        priority if (cmd.start) begin
            busy_next = !status.zero_len;
        end else if (cmd.step && status.last_step) begin
            busy_next = 1'b0;
        end else begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/dda_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dda_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [dda_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  wire logic [dda_pkg::OUT_USER_W-1:0]    m_tuser,
    input  wire logic                              m_tlast
);

    `DDA_ASSERT(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "stalled item changed")
    `DDA_ASSERT(a_we_pv, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> m_tuser[1], "write without pixel")
    `DDA_ASSERT(a_last_pv, aclk, aresetn, (m_tvalid && m_tlast) |-> m_tuser[1], "line end without pixel")
    `DDA_ASSERT(a_idle_zero, aclk, aresetn, (m_tvalid && !m_tuser[1]) |-> (m_tdata == '0), "inactive item carries data")
    `DDA_ASSERT_NR(a_rst, aclk, !aresetn |=> !m_tvalid, "item valid after reset")

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: sim/dda_pixel_checker.sv
`timescale 1ns / 1ps

module dda_pixel_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic [dda_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire logic                               s_tuser,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [dda_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  wire logic [dda_pkg::OUT_USER_W-1:0]     m_tuser,
    input  wire logic                               m_tlast,
    input  wire logic                               cfg_valid,
    input  wire logic                               cfg_ready,
    input  wire logic [dda_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dda_pkg::CANVAS_W-1:0]       cfg_data,
    output int                                      mismatches,
    output int                                      outstanding,
    output int                                      pixels_seen
);

    localparam int CB = dda_pkg::COORD_BITS;
    localparam int FB = dda_pkg::FRAC_BITS;
    localparam int CW = dda_pkg::COLOR_W;
    localparam int RW = dda_pkg::RND_W;
    localparam int IW = dda_pkg::INC_W;
    localparam int PW = dda_pkg::POS_W;
    localparam int SW = dda_pkg::SPAN_W;

    typedef struct packed {
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic [CW-1:0] color;
        logic          write_en;
        logic          valid;
        logic          done;
    } pixel_t;

    pixel_t expected_pixels[$];

    logic [dda_pkg::CANVAS_W-1:0] canvas_w;
    logic [dda_pkg::CANVAS_W-1:0] canvas_h;
    logic signed [PW-1:0]         pos_x;
    logic signed [PW-1:0]         pos_y;
    logic signed [IW-1:0]         inc_x;
    logic signed [IW-1:0]         inc_y;
    logic [SW-1:0]                steps_left;
    logic [CW-1:0]                color_hold;
    logic                         line_active;

    task automatic note_mismatch(input string field, input longint want, input longint got);
        $display("%0t: mismatch on %s: expected %0h, got %0h", $time, field, want, got);
        mismatches++;
    endtask

    task automatic expect_pixel(input pixel_t p);
        expected_pixels.insert(expected_pixels.size(), p);
    endtask

    // half away from zero
    function automatic logic signed [RW-1:0] to_pixel(input logic signed [PW-1:0] p);
        longint v;
        longint m;
        v = p;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (FB - 1))) >> FB;
        return (v < 0) ? RW'(-m) : RW'(m);
    endfunction

    // span / steps in fixed point, truncated toward zero
    function automatic logic signed [IW-1:0] step_increment(input longint span,
                                                            input longint nsteps);
        longint mag;
        longint q;
        mag = (span < 0) ? -span : span;
        q = (mag << FB) / nsteps;
        return (span < 0) ? IW'(-q) : IW'(q);
    endfunction

    function automatic pixel_t current_pixel(input logic done);
        pixel_t               p;
        logic signed [RW-1:0] rx;
        logic signed [RW-1:0] ry;
        rx = to_pixel(pos_x);
        ry = to_pixel(pos_y);
        p.px       = rx[CB-1:0];
        p.py       = ry[CB-1:0];
        p.color    = color_hold;
        p.write_en = (rx >= 0) && (longint'(rx) < longint'(canvas_w)) &&
                     (ry >= 0) && (longint'(ry) < longint'(canvas_h));
        p.valid    = 1'b1;
        p.done     = done;
        return p;
    endfunction

    always @(posedge aclk) begin
        pixel_t               got;
        pixel_t               want;
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic signed [CB-1:0] ex;
        logic signed [CB-1:0] ey;
        longint               dx;
        longint               dy;
        longint               adx;
        longint               ady;
        longint               nsteps;
        if (!aresetn) begin
            canvas_w    = dda_pkg::CANVAS_W_RESET;
            canvas_h    = dda_pkg::CANVAS_H_RESET;
            pos_x       = '0;
            pos_y       = '0;
            inc_x       = '0;
            inc_y       = '0;
            steps_left  = '0;
            color_hold  = '0;
            line_active = 1'b0;
            expected_pixels.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    dda_pkg::CFG_CANVAS_WIDTH:  canvas_w = cfg_data;
                    dda_pkg::CFG_CANVAS_HEIGHT: canvas_h = cfg_data;
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got.px       = m_tdata[CB-1:0];
                got.py       = m_tdata[2*CB-1:CB];
                got.color    = m_tdata[2*CB+CW-1:2*CB];
                got.write_en = m_tuser[0];
                got.valid    = m_tuser[1];
                got.done     = m_tlast;
                pixels_seen++;
                if (expected_pixels.size() == 0) begin
                    note_mismatch("result with none expected", 0, longint'(got.px));
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.px != want.px)
                        note_mismatch("pixel_x", longint'(want.px), longint'(got.px));
                    if (got.py != want.py)
                        note_mismatch("pixel_y", longint'(want.py), longint'(got.py));
                    if (got.color != want.color)
                        note_mismatch("pixel_color", longint'(want.color),
                                      longint'(got.color));
                    if (got.write_en != want.write_en)
                        note_mismatch("write_enable", longint'(want.write_en),
                                      longint'(got.write_en));
                    if (got.valid != want.valid)
                        note_mismatch("pixel_valid", longint'(want.valid),
                                      longint'(got.valid));
                    if (got.done != want.done)
                        note_mismatch("line_done", longint'(want.done), longint'(got.done));
                end
            end

            if (s_tvalid && s_tready) begin
                if (s_tuser == dda_pkg::FUNC_START) begin
                    sx = s_tdata[CB-1:0];
                    sy = s_tdata[2*CB-1:CB];
                    ex = s_tdata[3*CB-1:2*CB];
                    ey = s_tdata[4*CB-1:3*CB];
                    dx = longint'(ex) - longint'(sx);
                    dy = longint'(ey) - longint'(sy);
                    adx = (dx < 0) ? -dx : dx;
                    ady = (dy < 0) ? -dy : dy;
                    nsteps = (adx > ady) ? adx : ady;
                    pos_x = {sx, {FB{1'b0}}};
                    pos_y = {sy, {FB{1'b0}}};
                    color_hold = s_tdata[4*CB+CW-1:4*CB];
                    if (nsteps == 0) begin
                        inc_x = '0;
                        inc_y = '0;
                        steps_left = '0;
                        line_active = 1'b0;
                        expect_pixel(current_pixel(1'b1));
                    end else begin
                        inc_x = step_increment(dx, nsteps);
                        inc_y = step_increment(dy, nsteps);
                        steps_left = SW'(nsteps);
                        line_active = 1'b1;
                        expect_pixel(current_pixel(1'b0));
                    end
                end else if (!line_active) begin
                    expect_pixel('0);
                end else begin
                    pos_x = pos_x + inc_x;
                    pos_y = pos_y + inc_y;
                    steps_left = steps_left - 1'b1;
                    if (steps_left == 0)
                        line_active = 1'b0;
                    expect_pixel(current_pixel(steps_left == 0));
                end
            end
        end
        outstanding = expected_pixels.size();
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 185;
    localparam int HOLDOFF_LEN   = 300;

    localparam int CB    = dda_pkg::COORD_BITS;
    localparam int CLR_W = dda_pkg::COLOR_W;
    localparam int CNV_W = dda_pkg::CANVAS_W;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [dda_pkg::IN_DATA_W-1:0]     s_tdata;
    logic                              s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [dda_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic [dda_pkg::OUT_USER_W-1:0]    m_tuser;
    logic                              m_tlast;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [dda_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [CNV_W-1:0]                  cfg_data;

    int mismatches;
    int outstanding;
    int pixels_seen;
    int cycles = 0;
    int items_sent = 0;
    int lines_started = 0;
    int stall_left;
    int cur_w = 1280;
    int cur_h = 720;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;
    bit hold_active = 1'b0;

    dda_line_rasterizer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dda_pixel_checker pixel_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .pixels_seen (pixels_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) cycles <= cycles + 1;

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d pixels still expected", cycles, outstanding);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 60)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(5, 40));
    endfunction

    // receiver
    initial begin
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_active) begin
                m_tready = 1'b0;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap();
                m_tready = (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // long output stall, timed on its own
    initial begin
        wait (hold_req);
        @(posedge aclk);
        hold_active = 1'b1;
        repeat (HOLDOFF_LEN) @(posedge aclk);
        hold_active = 1'b0;
    end

    function automatic int line_steps(input int sx, input int sy, input int ex, input int ey);
        int ax;
        int ay;
        ax = ex - sx;
        ay = ey - sy;
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        return (ax > ay) ? ax : ay;
    endfunction

    // entered and left at a falling edge
    task automatic send_item(input logic func, input int sx, input int sy, input int ex,
                             input int ey, input logic [CLR_W-1:0] color);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = {color, CB'(ey), CB'(ex), CB'(sy), CB'(sx)};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (func == dda_pkg::FUNC_START)
            lines_started++;
        @(negedge aclk);
    endtask

    task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                             input logic [CLR_W-1:0] color, input int nsteps);
        send_item(dda_pkg::FUNC_START, sx, sy, ex, ey, color);
        repeat (nsteps) send_item(dda_pkg::FUNC_STEP, int'($urandom()), int'($urandom()),
                                  int'($urandom()), int'($urandom()), CLR_W'($urandom()));
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_register(input logic [dda_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [CNV_W-1:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_canvas(input int w, input int h);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_register(dda_pkg::CFG_CANVAS_WIDTH, CNV_W'(w));
        write_register(dda_pkg::CFG_CANVAS_HEIGHT, CNV_W'(h));
        cur_w = w;
        cur_h = h;
    endtask

    task automatic random_lines(input int n_items);
        int base;
        int r;
        int sx;
        int sy;
        int ex;
        int ey;
        int n;
        base = items_sent;
        while (items_sent - base < n_items) begin
            r = int'($urandom_range(0, 99));
            if (r < 74) begin
                sx = int'($urandom_range(0, cur_w + 20)) - 10;
                sy = int'($urandom_range(0, cur_h + 20)) - 10;
                if ($urandom_range(0, 9) == 0) begin
                    ex = sx;
                    ey = sy;
                end else begin
                    ex = sx + int'($urandom_range(0, 60)) - 30;
                    ey = sy + int'($urandom_range(0, 60)) - 30;
                end
                n = line_steps(sx, sy, ex, ey);
                r = int'($urandom_range(0, 9));
                if (r < 7)
                    draw_line(sx, sy, ex, ey, CLR_W'($urandom()), n);
                else if (r < 9)
                    draw_line(sx, sy, ex, ey, CLR_W'($urandom()), int'($urandom_range(0, n)));
                else
                    draw_line(sx, sy, ex, ey, CLR_W'($urandom()),
                              n + int'($urandom_range(1, 3)));
            end else if (r < 78) begin
                sx = int'($urandom_range(0, cur_w + 20)) - 10;
                sy = int'($urandom_range(0, cur_h + 20)) - 10;
                ex = sx + int'($urandom_range(0, 300)) - 150;
                ey = sy + int'($urandom_range(0, 300)) - 150;
                draw_line(sx, sy, ex, ey, CLR_W'($urandom()), line_steps(sx, sy, ex, ey));
            end else if (r < 90) begin
                draw_line(int'($urandom()), int'($urandom()), int'($urandom()),
                          int'($urandom()), CLR_W'($urandom()), int'($urandom_range(0, 6)));
            end else begin
                send_item(1'($urandom_range(0, 1)), int'($urandom()), int'($urandom()),
                          int'($urandom()), int'($urandom()), CLR_W'($urandom()));
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = dda_pkg::FUNC_START;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = dda_pkg::CFG_CANVAS_WIDTH;
        cfg_data  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed, reset canvas
        send_item(dda_pkg::FUNC_STEP, 'h1234, 'h5678, 'h9abc, 'hdef0, 24'h123456);
        draw_line(5, 5, 5, 5, 24'h00ff00, 0);
        draw_line(0, 0, 1, 2, 24'h0000ff, 3);
        draw_line(0, 0, -1, 2, 24'hff0000, 2);
        draw_line(-32768, -32768, 32767, 32767, 24'hffffff, 2);
        draw_line(32767, -32768, -32768, 32767, 24'h000000, 1);
        draw_line(1279, 719, 1281, 721, 24'haa55aa, 2);
        draw_line(-2, 3, 1, 3, 24'h55aa55, 4);
        draw_line(0, 0, 1, 3, 24'h808080, 3);

        set_canvas(1, 1);
        random_lines(PHASE_ITEMS);
        set_canvas(0, 0);
        random_lines(PHASE_ITEMS);
        set_canvas(8191, 8191);
        random_lines(PHASE_ITEMS);
        set_canvas(640, 480);
        hold_req = 1'b1;
        random_lines(PHASE_ITEMS);
        set_canvas(4096, 4096);
        random_lines(PHASE_ITEMS);
        set_canvas(int'($urandom_range(1, 4096)), int'($urandom_range(1, 4096)));
        no_idle = 1'b1;
        random_lines(PHASE_ITEMS);
        no_idle = 1'b0;
        set_canvas(1280, 720);
        random_lines(PHASE_ITEMS);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("sent %0d items in %0d lines, checked %0d pixels over 7 canvas sizes",
                 items_sent, lines_started, pixels_seen);
        $display("covered idle steps, abandoned lines, clipping and a %0d-cycle output stall",
                 HOLDOFF_LEN);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/dda_pkg.sv
sv/dda_div.sv
sv/dda_dp.sv
sv/dda_ctrl.sv
sv/dda_line_rasterizer.sv
sv/dda_checker.sv
sim/dda_pixel_checker.sv
sim/testbench.sv
